/* hw/rtl/hfsa_pkg.sv */
`timescale 1ns / 1ps

package hfsa_pkg;

  localparam int HFSA_TEMPLATES = 65536;
  localparam int HFSA_FRAC_BITS = 16;

  localparam int REF_W   = 17;
  localparam int SCORE_W = 16;
  localparam int CNT_W   = 17;
  localparam int ACC_W   = 64;
  localparam int MODE_W  = 2;
  localparam int THR_W   = 17;
  localparam int PROD_W  = THR_W + SCORE_W;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 152;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [THR_W-1:0] THR_RESET = 17'h10000;

  localparam logic [MODE_W-1:0] MODE_EXACT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRAC_OWN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FRAC_BEST = 2'd2;

  localparam logic CMD_HIT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic CFG_MATCH_MODE = 1'b0;
  localparam logic CFG_THRESHOLD  = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] match_mode;
    logic [THR_W-1:0]  threshold_frac;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] unique_score;
    logic [ACC_W-1:0] total_score;
    logic             run_done;
    logic [CNT_W-1:0] accepted_count;
    logic             accepted;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_UNQ,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/hfsa_ram.sv */
`timescale 1ns / 1ps

module hfsa_ram
  import hfsa_pkg::*;
#(
  parameter int DEPTH = HFSA_TEMPLATES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ACC_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [ACC_W-1:0] rdata
);

  logic [ACC_W-1:0] mem [DEPTH];
  logic [ACC_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/hfsa_ctrl.sv */
`timescale 1ns / 1ps

module hfsa_ctrl
  import hfsa_pkg::*;
#(
  parameter int TEMPLATES = HFSA_TEMPLATES,
  parameter int FRAC_BITS = HFSA_FRAC_BITS,
  localparam int AW = $clog2(TEMPLATES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   tot_we,
  output logic [AW-1:0]          tot_waddr,
  output logic [ACC_W-1:0]       tot_wdata,
  output logic [AW-1:0]          tot_raddr,
  input  logic [ACC_W-1:0]       tot_rdata,
  output logic                   uni_we,
  output logic [AW-1:0]          uni_waddr,
  output logic [ACC_W-1:0]       uni_wdata,
  output logic [AW-1:0]          uni_raddr,
  input  logic [ACC_W-1:0]       uni_rdata
);

  localparam int SH_W = SCORE_W + FRAC_BITS;
  localparam int CW   = (SH_W > PROD_W) ? SH_W : PROD_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TEMPLATES - 1);

  state_t state_r, state_nxt;

  logic [AW-1:0]      clr_cnt_r;
  logic               cmd_r;
  logic [REF_W-1:0]   mag_r;
  logic [SCORE_W-1:0] hit_r;
  logic [SCORE_W-1:0] best_r;
  logic               last_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REF_W-1:0]   sole_r, sole_nxt;
  res_t               res_r, res_nxt;
  res_t               out_res_r;
  logic               out_valid_r;

  logic [REF_W-1:0]   ref_in;
  logic [REF_W-1:0]   mag_in;
  logic               accept_in;
  logic               out_load;

  logic [31:0]        mag_w;
  logic [31:0]        sole_acc_w;
  logic [31:0]        sole_w;
  logic [AW-1:0]      item_addr;
  logic [AW-1:0]      sole_acc_addr;
  logic [AW-1:0]      sole_addr;

  logic [CW-1:0]      hit_sh;
  logic               pass;
  logic               acc;
  logic [ACC_W-1:0]   add_val;
  logic [ACC_W-1:0]   tot_new;
  logic [ACC_W-1:0]   uni_new;
  logic               item_in_rng;
  logic               sole_in_rng;
  logic [CNT_W-1:0]   cnt_acc;
  logic [REF_W-1:0]   sole_acc;
  logic               uni_upd;
  logic               sole_same;

  assign ref_in    = in_tdata[REF_W-1:0];
  assign mag_in    = ref_in[REF_W-1] ? REF_W'(~ref_in + 1'b1) : ref_in;
  assign accept_in = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  assign mag_w         = 32'(mag_r);
  assign item_addr     = mag_w[AW-1:0];
  assign sole_w        = 32'(sole_r);
  assign sole_addr     = sole_w[AW-1:0];

  assign hit_sh      = CW'(hit_r) << FRAC_BITS;
  assign pass        = (cfg.match_mode == MODE_EXACT) ? (hit_r == best_r)
                                                      : (hit_sh >= CW'(prod_r));
  assign acc         = (cmd_r == CMD_HIT) && pass;
  assign add_val     = (cfg.match_mode == MODE_FRAC_OWN) ? ACC_W'(hit_r) : ACC_W'(best_r);
  assign tot_new     = tot_rdata + add_val;
  assign uni_new     = uni_rdata + ACC_W'(best_r);
  assign item_in_rng = mag_w < 32'(TEMPLATES);
  assign cnt_acc     = (acc && (cnt_r != CNT_MAX)) ? cnt_r + 1'b1 : cnt_r;
  assign sole_acc    = acc ? mag_r : sole_r;
  assign sole_acc_w  = 32'(sole_acc);
  assign sole_acc_addr = sole_acc_w[AW-1:0];
  assign sole_in_rng = sole_acc_w < 32'(TEMPLATES);
  assign sole_same   = (sole_acc == mag_r);
  assign uni_upd     = (cmd_r == CMD_HIT) && last_r && (cnt_acc == CNT_W'(1)) && sole_in_rng;

  always_comb begin
    cnt_nxt  = cnt_r;
    sole_nxt = sole_r;
    if ((state_r == ST_EXEC) && (cmd_r == CMD_HIT)) begin
      cnt_nxt  = last_r ? '0 : cnt_acc;
      sole_nxt = sole_acc;
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (state_r == ST_EXEC) begin
      res_nxt.accepted       = acc;
      res_nxt.accepted_count = (cmd_r == CMD_HIT) ? cnt_acc : cnt_r;
      res_nxt.run_done       = (cmd_r == CMD_HIT) && last_r;
      res_nxt.total_score    = item_in_rng ? (acc ? tot_new : tot_rdata) : '0;
      res_nxt.unique_score   = item_in_rng ? ((uni_upd && sole_same) ? uni_new : uni_rdata)
                                           : '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept_in) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = (uni_upd && !sole_same) ? ST_UNQ : ST_OUT;
      ST_UNQ:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    tot_we    = 1'b0;
    tot_waddr = item_addr;
    tot_wdata = tot_new;
    tot_raddr = item_addr;
    uni_we    = 1'b0;
    uni_waddr = item_addr;
    uni_wdata = uni_new;
    uni_raddr = item_addr;
    case (state_r)
      ST_CLEAR: begin
        tot_we    = 1'b1;
        tot_waddr = clr_cnt_r;
        tot_wdata = '0;
        uni_we    = 1'b1;
        uni_waddr = clr_cnt_r;
        uni_wdata = '0;
      end
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: begin
        tot_we    = acc && item_in_rng;
        uni_we    = uni_upd && sole_same;
        uni_raddr = sole_acc_addr;
      end
      ST_UNQ: begin
        uni_we    = 1'b1;
        uni_waddr = sole_addr;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      sole_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sole_r  <= sole_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      cmd_r  <= in_tuser;
      mag_r  <= mag_in;
      hit_r  <= in_tdata[REF_W +: SCORE_W];
      best_r <= in_tdata[REF_W+SCORE_W +: SCORE_W];
      last_r <= in_tlast;
    end
    if (state_r == ST_READ) begin
      prod_r <= cfg.threshold_frac * best_r;
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.run_done;
  assign out_tdata  = {6'd0, out_res_r.unique_score, out_res_r.total_score,
                       out_res_r.accepted_count, out_res_r.accepted};

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("Input accepted during the table clearing pass.");

  a_total_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    (tot_we && (state_r != ST_CLEAR)) |-> (state_r == ST_EXEC))
    else $error("Total table written outside the update step.");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && (cmd_r == CMD_HIT) && last_r) |=> (cnt_r == '0))
    else $error("Accept count not cleared after the last hit of a read.");

  a_unique_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UNQ) |-> $past(state_r == ST_EXEC))
    else $error("Unique table update not preceded by the update step.");

endmodule

/* hw/rtl/hit_filter_score_accumulator.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in_      slave      in_tvalid / in_tready    tdata: ref, hit, best; tuser: cmd; tlast
// out_     master     out_tvalid / out_tready  tdata: accepted, count, total, unique; tlast
// cfg_     slave      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The output register is loaded after the accepted item is captured, both tables are read
// (ST_READ), then updated (ST_EXEC), and the result is registered and waits in ST_OUT until
// the output register is free. The next input is accepted once the block is back in ST_IDLE.
// A read's last hit that credits the unique table at a template other than its own also
// passes through ST_UNQ for that second access to the single unique-table read port.
// After reset both tables are cleared entry by entry, during which no input
// transaction is accepted; configuration writes are always taken.
// A new input is accepted while the previous result still waits in the output register;
// its result then holds the block until the waiting one has been taken.

module hit_filter_score_accumulator
  import hfsa_pkg::*;
#(
  parameter int TEMPLATES = HFSA_TEMPLATES,
  parameter int FRAC_BITS = HFSA_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // template_ref[16:0], hit_score, best_score, pad
  input  logic                   in_tuser,   // cmd
  input  logic                   in_tlast,   // last_hit
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // accepted, accepted_count, total, unique, pad
  output logic                   out_tlast,  // run_done
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [THR_W-1:0]       cfg_data
);

  localparam int AW = $clog2(TEMPLATES);

  logic [MODE_W-1:0] mode_r;
  logic [THR_W-1:0]  thr_r;
  cfg_t              cfg;

  logic              tot_we,    uni_we;
  logic [AW-1:0]     tot_waddr, uni_waddr;
  logic [ACC_W-1:0]  tot_wdata, uni_wdata;
  logic [AW-1:0]     tot_raddr, uni_raddr;
  logic [ACC_W-1:0]  tot_rdata, uni_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_EXACT;
      thr_r  <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MATCH_MODE: mode_r <= cfg_data[MODE_W-1:0];
        CFG_THRESHOLD:  thr_r  <= cfg_data;
        default:        mode_r <= mode_r;
      endcase
    end
  end

  assign cfg.match_mode     = mode_r;
  assign cfg.threshold_frac = thr_r;

  hfsa_ram #(.DEPTH(TEMPLATES)) u_total_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  hfsa_ram #(.DEPTH(TEMPLATES)) u_unique_ram (
    .clk   (clk),
    .we    (uni_we),
    .waddr (uni_waddr),
    .wdata (uni_wdata),
    .raddr (uni_raddr),
    .rdata (uni_rdata)
  );

  hfsa_ctrl #(
    .TEMPLATES (TEMPLATES),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .tot_we     (tot_we),
    .tot_waddr  (tot_waddr),
    .tot_wdata  (tot_wdata),
    .tot_raddr  (tot_raddr),
    .tot_rdata  (tot_rdata),
    .uni_we     (uni_we),
    .uni_waddr  (uni_waddr),
    .uni_wdata  (uni_wdata),
    .uni_raddr  (uni_raddr),
    .uni_rdata  (uni_rdata)
  );

endmodule
